// ===== rtl/sfcd_pkg.sv =====
package sfcd_pkg;

    // Frame layout
    localparam int unsigned FRAME_BYTES   = 25;
    localparam int unsigned POS_W         = 5;
    localparam logic [7:0]  HEADER_BYTE   = 8'h0F;
    localparam logic [POS_W-1:0] POS_HUNT      = 5'd0;
    localparam logic [POS_W-1:0] POS_LAST_DATA = 5'd22;
    localparam logic [POS_W-1:0] POS_FLAGS     = 5'd23;

    // Channel packing
    localparam int unsigned CHAN_BITS  = 11;
    localparam int unsigned CHAN_NUM_W = 4;
    localparam int unsigned CHAN_CNT_W = 5;
    localparam int unsigned ACC_W      = 19;
    localparam int unsigned HELD_W     = 4;
    localparam logic [CHAN_BITS-1:0] CHAN_MAX = 11'h7FF;
    localparam int unsigned NUM_CHANNELS_DEF = 16;

    // Result kinds
    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Configuration registers
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALED_CHANNEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALED_OFFSET  = 1'd1;
    localparam logic [CHAN_NUM_W-1:0] SCALED_CHANNEL_RST = 4'd2;
    localparam logic [CHAN_BITS-1:0]  SCALED_OFFSET_RST  = 11'd1000;

    // Item passed from the unpacker to the output stage
    typedef struct packed {
        logic                  kind;
        logic [CHAN_NUM_W-1:0] ch;
        logic [CHAN_BITS-1:0]  raw;
        logic                  flags_set;
    } t_chan_item;

endpackage

// ===== rtl/sfcd_unpack.sv =====
module sfcd_unpack #(
    parameter int unsigned NUM_CHANNELS = sfcd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_item_vld,
    input  logic                  i_item_rdy,
    output sfcd_pkg::t_chan_item  o_item
);

    localparam logic [sfcd_pkg::CHAN_CNT_W-1:0] NUM_CH =
        sfcd_pkg::CHAN_CNT_W'(NUM_CHANNELS);

    logic [sfcd_pkg::POS_W-1:0]      r_pos,  n_pos;
    logic [sfcd_pkg::ACC_W-1:0]      r_acc,  n_acc;
    logic [sfcd_pkg::HELD_W-1:0]     r_held, n_held;
    logic [sfcd_pkg::CHAN_CNT_W-1:0] r_nch,  n_nch;
    logic                            r_vld,  n_vld;
    sfcd_pkg::t_chan_item            r_item, n_item;

    logic                            accept;
    logic [sfcd_pkg::ACC_W-1:0]      acc_or;
    logic [sfcd_pkg::HELD_W:0]       held_sum;

    assign o_ready    = !r_vld || i_item_rdy;
    assign accept     = i_valid && o_ready;
    assign o_item_vld = r_vld;
    assign o_item     = r_item;

    // Merge the new byte above the bits already held
    assign acc_or   = r_acc | (sfcd_pkg::ACC_W'(i_rx_byte) << r_held);
    assign held_sum = {1'b0, r_held} + (sfcd_pkg::HELD_W + 1)'(8);

    // Frame parser and bit unpacker
    always_comb begin
        n_pos  = r_pos;
        n_acc  = r_acc;
        n_held = r_held;
        n_nch  = r_nch;
        n_vld  = r_vld && !i_item_rdy;
        n_item = r_item;
        if (accept) begin
            if (r_pos == sfcd_pkg::POS_HUNT) begin
                if (i_rx_byte == sfcd_pkg::HEADER_BYTE) begin
                    n_pos  = sfcd_pkg::POS_W'(1);
                    n_acc  = '0;
                    n_held = '0;
                    n_nch  = '0;
                end
            end else if (r_pos <= sfcd_pkg::POS_LAST_DATA) begin
                n_pos = r_pos + sfcd_pkg::POS_W'(1);
                if (held_sum >= (sfcd_pkg::HELD_W + 1)'(sfcd_pkg::CHAN_BITS)) begin
                    n_acc  = acc_or >> sfcd_pkg::CHAN_BITS;
                    n_held = sfcd_pkg::HELD_W'(held_sum
                             - (sfcd_pkg::HELD_W + 1)'(sfcd_pkg::CHAN_BITS));
                    n_nch  = r_nch + sfcd_pkg::CHAN_CNT_W'(1);
                    if (r_nch < NUM_CH) begin
                        n_vld            = 1'b1;
                        n_item.kind      = sfcd_pkg::KIND_CHANNEL;
                        n_item.ch        = r_nch[sfcd_pkg::CHAN_NUM_W-1:0];
                        n_item.raw       = acc_or[sfcd_pkg::CHAN_BITS-1:0];
                        n_item.flags_set = 1'b0;
                    end
                end else begin
                    n_acc  = acc_or;
                    n_held = held_sum[sfcd_pkg::HELD_W-1:0];
                end
            end else if (r_pos == sfcd_pkg::POS_FLAGS) begin
                n_pos            = r_pos + sfcd_pkg::POS_W'(1);
                n_vld            = 1'b1;
                n_item.kind      = sfcd_pkg::KIND_STATUS;
                n_item.ch        = '0;
                n_item.raw       = '0;
                n_item.flags_set = (i_rx_byte != 8'd0);
            end else begin
                // trailing byte closes the frame
                n_pos  = sfcd_pkg::POS_HUNT;
                n_acc  = '0;
                n_held = '0;
                n_nch  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= sfcd_pkg::POS_HUNT;
            r_acc  <= '0;
            r_held <= '0;
            r_nch  <= '0;
            r_vld  <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_acc  <= n_acc;
            r_held <= n_held;
            r_nch  <= n_nch;
            r_vld  <= n_vld;
        end
        r_item <= n_item;
    end

endmodule

// ===== rtl/sfcd_scale.sv =====
module sfcd_scale (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sfcd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sfcd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_item_vld,
    output logic                                 o_item_rdy,
    input  sfcd_pkg::t_chan_item                 i_item,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_kind,
    output logic [sfcd_pkg::CHAN_NUM_W-1:0]      o_channel_number,
    output logic [sfcd_pkg::CHAN_BITS-1:0]       o_channel_value,
    output logic                                 o_flags_set,
    output logic                                 o_frame_last
);

    logic [sfcd_pkg::CHAN_NUM_W-1:0] r_scaled_ch;
    logic [sfcd_pkg::CHAN_BITS-1:0]  r_scaled_off;
    logic                            r_vld;
    sfcd_pkg::t_chan_item            r_out;

    logic                            load;
    logic [sfcd_pkg::CHAN_BITS:0]    sum;
    logic [sfcd_pkg::CHAN_BITS-1:0]  scaled;
    sfcd_pkg::t_chan_item            n_out;

    assign o_item_rdy = !r_vld || i_ready;
    assign load       = i_item_vld && o_item_rdy;

    // Half value plus offset, saturated to 11 bits
    assign sum    = {2'b00, i_item.raw[sfcd_pkg::CHAN_BITS-1:1]} + {1'b0, r_scaled_off};
    assign scaled = sum[sfcd_pkg::CHAN_BITS] ? sfcd_pkg::CHAN_MAX
                                             : sum[sfcd_pkg::CHAN_BITS-1:0];

    always_comb begin
        n_out = i_item;
        if (i_item.kind == sfcd_pkg::KIND_CHANNEL && i_item.ch == r_scaled_ch) begin
            n_out.raw = scaled;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scaled_ch  <= sfcd_pkg::SCALED_CHANNEL_RST;
            r_scaled_off <= sfcd_pkg::SCALED_OFFSET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfcd_pkg::CFG_SCALED_CHANNEL:
                    r_scaled_ch <= i_cfg_data[sfcd_pkg::CHAN_NUM_W-1:0];
                sfcd_pkg::CFG_SCALED_OFFSET:
                    r_scaled_off <= i_cfg_data[sfcd_pkg::CHAN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_item_rdy) begin
            r_vld <= i_item_vld;
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_valid          = r_vld;
    assign o_kind           = r_out.kind;
    assign o_channel_number = r_out.ch;
    assign o_channel_value  = r_out.raw;
    assign o_flags_set      = r_out.flags_set;
    assign o_frame_last     = r_out.kind;

endmodule

// ===== rtl/sbus_frame_channel_decoder_unit.sv =====
// Receiver frame decoder: one byte in per cycle, results are channels and frame status.
// A result is registered in the unpack stage and then in the scale stage before the output.
// Throughput: one byte per cycle; the unpack register and the result register
// each take a new item while the next stage is ready or empty.
// Reset (i_rst_n low, synchronous): parser hunts for a header, both stages empty,
// scaled channel 2 and offset 1000.
module sbus_frame_channel_decoder_unit #(
    parameter int unsigned NUM_CHANNELS = sfcd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [7:0]                           i_rx_byte,
    input  logic                                 i_cfg_we,
    input  logic [sfcd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sfcd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_kind,
    output logic [sfcd_pkg::CHAN_NUM_W-1:0]      o_channel_number,
    output logic [sfcd_pkg::CHAN_BITS-1:0]       o_channel_value,
    output logic                                 o_flags_set,
    output logic                                 o_frame_last
);

    logic                 item_vld;
    logic                 item_rdy;
    sfcd_pkg::t_chan_item item;

    sfcd_unpack #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_unpack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_rx_byte  (i_rx_byte),
        .o_item_vld (item_vld),
        .i_item_rdy (item_rdy),
        .o_item     (item)
    );

    sfcd_scale u_scale (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_item_vld       (item_vld),
        .o_item_rdy       (item_rdy),
        .i_item           (item),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_channel_number (o_channel_number),
        .o_channel_value  (o_channel_value),
        .o_flags_set      (o_flags_set),
        .o_frame_last     (o_frame_last)
    );

endmodule
